[rtl/core/spwm_pkg.sv]
// Shared types and constants for the servo pulse sweep generator.
package spwm_pkg;

  // Default counter width
  localparam int unsigned CountBitsDef = 16;

  // Register file geometry
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned WidthBits   = 16;
  localparam int unsigned FrameBits   = 8;

  // Register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_FRAME_PERIOD    = 3'd0,
    REG_SWEEP_LOW       = 3'd1,
    REG_SWEEP_HIGH      = 3'd2,
    REG_SWEEP_STEP      = 3'd3,
    REG_FRAMES_PER_STEP = 3'd4,
    REG_WIDTH_B         = 3'd5
  } spwm_reg_e;

  // Register reset values
  localparam logic [WidthBits-1:0] FramePeriodRst   = 16'd20000;
  localparam logic [WidthBits-1:0] SweepLowRst      = 16'd600;
  localparam logic [WidthBits-1:0] SweepHighRst     = 16'd2400;
  localparam logic [WidthBits-1:0] SweepStepRst     = 16'd3;
  localparam logic [FrameBits-1:0] FramesPerStepRst = 8'd5;
  localparam logic [WidthBits-1:0] WidthBRst        = 16'd1500;

  // Latched width reset value
  localparam logic [WidthBits-1:0] LatchedWidthRst  = 16'd1500;

endpackage

[rtl/core/spwm_if.sv]
// Valid/ready channel interfaces for tick items and result items.
interface spwm_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface spwm_res_if;
  logic        valid;
  logic        ready;
  logic        pulse_a;
  logic        pulse_b;
  logic        frame_start;
  logic [15:0] sweep_width;

  modport source (output valid, output pulse_a, output pulse_b, output frame_start,
                  output sweep_width, input ready);
  modport sink   (input valid, input pulse_a, input pulse_b, input frame_start,
                  input sweep_width, output ready);
endinterface

[rtl/core/servo_pwm_sweep.sv]
// Top level of the two-channel servo pulse generator with triangle sweep.
//
// Usage: each item on in_i carries one tick bit. A tick of 1 advances the
// tick counter by one; a tick of 0 changes nothing. Every accepted item
// yields exactly one result item on out_o: both channel levels, a frame
// start flag and the current channel A sweep width.
// The result of an item is presented from the result register in the cycle
// after the item is accepted.
// Throughput: one item per cycle while the receiver takes each result; the tick
// step is combinational adds and compares ahead of the state and result registers.
// Stall: in_i.ready follows the result register; while a result waits and
// the receiver holds ready low, no new item is taken. When the result is
// taken in the same cycle, a new item enters at once.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i; write only
// while idle. Writes do not disturb counter or sweep state.
// Reset: rst_ni clears the counter, levels and sweep direction, loads the
// register defaults and starts the sweep at the default low bound.
module servo_pwm_sweep
  import spwm_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  spwm_tick_if.sink              in_i,
  spwm_res_if.source             out_o
);

  // Compare width covers both the counter and the 16 bit registers
  localparam int unsigned CmpBits = (COUNT_BITS > WidthBits) ? COUNT_BITS : WidthBits;

  // Configuration registers
  logic [WidthBits-1:0] frame_period_q, sweep_low_q, sweep_high_q, sweep_step_q, width_b_q;
  logic [FrameBits-1:0] frames_per_step_q;

  // Generator state
  logic [COUNT_BITS-1:0] tick_count_q, tick_count_d;
  logic [WidthBits-1:0]  lat_a_q, lat_a_d, lat_b_q, lat_b_d;
  logic                  level_a_q, level_a_d, level_b_q, level_b_d;
  logic [WidthBits-1:0]  sweep_q, sweep_d;
  logic                  falling_q, falling_d;
  logic [FrameBits-1:0]  frames_q, frames_d;
  logic                  start_d;

  // Result register
  logic                  res_valid_q;
  logic                  res_a_q, res_b_q, res_start_q;
  logic [WidthBits-1:0]  res_width_q;

  logic                  accept;
  logic [COUNT_BITS-1:0] next_cnt;
  logic [CmpBits-1:0]    next_ext, period_ext, lat_a_ext, lat_b_ext;
  logic [FrameBits-1:0]  frames_inc;
  logic [WidthBits:0]    sweep_up, low_plus_step;

  // Take an item when the result register is empty or being drained
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_period_q    <= FramePeriodRst;
      sweep_low_q       <= SweepLowRst;
      sweep_high_q      <= SweepHighRst;
      sweep_step_q      <= SweepStepRst;
      frames_per_step_q <= FramesPerStepRst;
      width_b_q         <= WidthBRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_PERIOD:    frame_period_q    <= cfg_data_i;
        REG_SWEEP_LOW:       sweep_low_q       <= cfg_data_i;
        REG_SWEEP_HIGH:      sweep_high_q      <= cfg_data_i;
        REG_SWEEP_STEP:      sweep_step_q      <= cfg_data_i;
        REG_FRAMES_PER_STEP: frames_per_step_q <= cfg_data_i[FrameBits-1:0];
        REG_WIDTH_B:         width_b_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Widen operands for the counter compares
  assign next_cnt      = tick_count_q + COUNT_BITS'(1);
  assign next_ext      = CmpBits'(next_cnt);
  assign period_ext    = CmpBits'(frame_period_q);
  assign lat_a_ext     = CmpBits'(lat_a_q);
  assign lat_b_ext     = CmpBits'(lat_b_q);
  assign frames_inc    = frames_q + FrameBits'(1);
  assign sweep_up      = {1'b0, sweep_q} + {1'b0, sweep_step_q};
  assign low_plus_step = {1'b0, sweep_low_q} + {1'b0, sweep_step_q};

  // Advance the tick counter, levels and sweep for one tick
  always_comb begin
    tick_count_d = tick_count_q;
    lat_a_d      = lat_a_q;
    lat_b_d      = lat_b_q;
    level_a_d    = level_a_q;
    level_b_d    = level_b_q;
    sweep_d      = sweep_q;
    falling_d    = falling_q;
    frames_d     = frames_q;
    start_d      = 1'b0;
    if (in_i.tick) begin
      if (next_ext >= period_ext) begin
        // Restart the frame and latch both widths
        tick_count_d = '0;
        level_a_d    = 1'b1;
        level_b_d    = 1'b1;
        lat_a_d      = sweep_q;
        lat_b_d      = width_b_q;
        start_d      = 1'b1;
        frames_d     = frames_inc;
        if (frames_inc >= frames_per_step_q) begin
          frames_d = '0;
          if (!falling_q) begin
            if (sweep_up >= {1'b0, sweep_high_q}) begin
              sweep_d   = sweep_high_q;
              falling_d = 1'b1;
            end else begin
              sweep_d = sweep_up[WidthBits-1:0];
            end
          end else begin
            if ({1'b0, sweep_q} <= low_plus_step) begin
              sweep_d   = sweep_low_q;
              falling_d = 1'b0;
            end else begin
              sweep_d = sweep_q - sweep_step_q;
            end
          end
        end
      end else begin
        // Drop each channel at its width
        tick_count_d = next_cnt;
        if (next_ext == lat_a_ext) begin
          level_a_d = 1'b0;
        end
        if (next_ext == lat_b_ext) begin
          level_b_d = 1'b0;
        end
      end
    end
  end

  // Hold generator state, update on accepted items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      lat_a_q      <= LatchedWidthRst;
      lat_b_q      <= LatchedWidthRst;
      level_a_q    <= 1'b0;
      level_b_q    <= 1'b0;
      sweep_q      <= SweepLowRst;
      falling_q    <= 1'b0;
      frames_q     <= '0;
    end else if (accept) begin
      tick_count_q <= tick_count_d;
      lat_a_q      <= lat_a_d;
      lat_b_q      <= lat_b_d;
      level_a_q    <= level_a_d;
      level_b_q    <= level_b_d;
      sweep_q      <= sweep_d;
      falling_q    <= falling_d;
      frames_q     <= frames_d;
    end
  end

  // Track result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_a_q     <= level_a_d;
      res_b_q     <= level_b_d;
      res_start_q <= start_d;
      res_width_q <= sweep_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.pulse_a     = res_a_q;
  assign out_o.pulse_b     = res_b_q;
  assign out_o.frame_start = res_start_q;
  assign out_o.sweep_width = res_width_q;

endmodule

[sim/spwm_sweep_checker.sv]
// Predicts servo pulse results from observed ticks and register writes and compares them.
module spwm_sweep_checker
  import spwm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  spwm_tick_if                   ticks_i,
  spwm_res_if                    results_i,
  output int unsigned            errors_o,
  output int unsigned            pending_o,
  output int unsigned            checked_o,
  output int unsigned            frames_o
);

  typedef struct packed {
    logic                 pulse_a;
    logic                 pulse_b;
    logic                 frame_start;
    logic [WidthBits-1:0] sweep_width;
  } servo_out_t;

  // Register copy
  logic [WidthBits-1:0] period_q, low_q, high_q, step_q, width_b_q;
  logic [FrameBits-1:0] frames_per_step_q;

  // Generator state copy
  logic [CountBitsDef-1:0] count_q;
  logic [WidthBits-1:0]    lat_a_q, lat_b_q, sweep_q;
  logic                    level_a_q, level_b_q, falling_q;
  logic [FrameBits-1:0]    waited_q;

  // Result items still owed by the block, oldest first
  servo_out_t levels_due_q[$];

  // Move the channel A width one step along the triangle, clamping at the bounds
  function automatic void step_sweep();
    logic [WidthBits:0] up;
    logic [WidthBits:0] floor_sum;
    up        = {1'b0, sweep_q} + {1'b0, step_q};
    floor_sum = {1'b0, low_q} + {1'b0, step_q};
    if (!falling_q) begin
      if (up >= {1'b0, high_q}) begin
        sweep_q   = high_q;
        falling_q = 1'b1;
      end else begin
        sweep_q = up[WidthBits-1:0];
      end
    end else if ({1'b0, sweep_q} <= floor_sum) begin
      sweep_q   = low_q;
      falling_q = 1'b0;
    end else begin
      sweep_q = sweep_q - step_q;
    end
  endfunction

  // Advance the generator by one item and return the levels it shows afterward
  function automatic servo_out_t servo_tick(input logic tk);
    logic [CountBitsDef-1:0] count_next;
    servo_out_t              res;
    res.frame_start = 1'b0;
    if (tk) begin
      count_next = count_q + 1'b1;
      if (count_next >= period_q) begin
        count_q         = '0;
        level_a_q       = 1'b1;
        level_b_q       = 1'b1;
        lat_a_q         = sweep_q;
        lat_b_q         = width_b_q;
        res.frame_start = 1'b1;
        waited_q        = waited_q + 1'b1;
        if (waited_q >= frames_per_step_q) begin
          waited_q = '0;
          step_sweep();
        end
      end else begin
        count_q = count_next;
        if (count_next == lat_a_q) level_a_q = 1'b0;
        if (count_next == lat_b_q) level_b_q = 1'b0;
      end
    end
    res.pulse_a     = level_a_q;
    res.pulse_b     = level_b_q;
    res.sweep_width = sweep_q;
    return res;
  endfunction

  // Print one mismatch line and count it
  task automatic flag_mismatch(input string msg);
    $display("mismatch at result %0d: %s", checked_o, msg);
    errors_o++;
  endtask

  // Compare taken results, predict new items, track register writes
  always @(posedge clk_i or negedge rst_ni) begin : watch
    servo_out_t want;
    servo_out_t got;
    if (!rst_ni) begin
      period_q          = FramePeriodRst;
      low_q             = SweepLowRst;
      high_q            = SweepHighRst;
      step_q            = SweepStepRst;
      frames_per_step_q = FramesPerStepRst;
      width_b_q         = WidthBRst;
      count_q           = '0;
      lat_a_q           = LatchedWidthRst;
      lat_b_q           = LatchedWidthRst;
      level_a_q         = 1'b0;
      level_b_q         = 1'b0;
      sweep_q           = SweepLowRst;
      falling_q         = 1'b0;
      waited_q          = '0;
      levels_due_q.delete();
      errors_o          = 0;
      pending_o         = 0;
      checked_o         = 0;
      frames_o          = 0;
    end else begin
      if (results_i.valid && results_i.ready) begin
        if (levels_due_q.size() == 0) begin
          flag_mismatch("result item with no tick item waiting");
        end else begin
          want = levels_due_q.pop_front();
          if (results_i.pulse_a !== want.pulse_a)
            flag_mismatch($sformatf("pulse_a got %b want %b", results_i.pulse_a, want.pulse_a));
          if (results_i.pulse_b !== want.pulse_b)
            flag_mismatch($sformatf("pulse_b got %b want %b", results_i.pulse_b, want.pulse_b));
          if (results_i.frame_start !== want.frame_start)
            flag_mismatch($sformatf("frame_start got %b want %b",
                                    results_i.frame_start, want.frame_start));
          if (results_i.sweep_width !== want.sweep_width)
            flag_mismatch($sformatf("sweep_width got %0d want %0d",
                                    results_i.sweep_width, want.sweep_width));
          checked_o++;
        end
      end
      if (ticks_i.valid && ticks_i.ready) begin
        got = servo_tick(ticks_i.tick);
        if (got.frame_start) frames_o++;
        levels_due_q.push_back(got);
      end
      // Writes are to land only while idle, which the checker does not enforce; unknown indexes drop
      if (cfg_we_i) begin
        case (spwm_reg_e'(cfg_idx_i))
          REG_FRAME_PERIOD:    period_q          = cfg_data_i;
          REG_SWEEP_LOW:       low_q             = cfg_data_i;
          REG_SWEEP_HIGH:      high_q            = cfg_data_i;
          REG_SWEEP_STEP:      step_q            = cfg_data_i;
          REG_FRAMES_PER_STEP: frames_per_step_q = cfg_data_i[FrameBits-1:0];
          REG_WIDTH_B:         width_b_q         = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = levels_due_q.size();
    end
  end

endmodule

[sim/tb.sv]
// Stimulus, receiver pacing and verdict for the servo pulse sweep generator.
module tb;
  import spwm_pkg::*;

  localparam logic [CfgIdxBits-1:0] RegSpare = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegLast  = 3'd7;
  localparam int unsigned Phases     = 12;
  localparam int unsigned PhaseItems = 145;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned HoldAfter  = 500;

  typedef struct {
    logic [15:0] period;
    logic [15:0] low;
    logic [15:0] high;
    logic [15:0] step;
    logic [15:0] fps_word;
    logic [15:0] width_b;
  } setup_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_data;
  logic                   tick_taken;
  int unsigned            ticks_sent;
  int unsigned            setups;
  int unsigned            errors, pending, checked, frames;

  spwm_tick_if tick_ch ();
  spwm_res_if  res_ch ();

  servo_pwm_sweep dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (tick_ch),
    .out_o      (res_ch)
  );

  spwm_sweep_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .ticks_i    (tick_ch),
    .results_i  (res_ch),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked),
    .frames_o   (frames)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note item handoffs for the sender
  always @(posedge clk) begin
    tick_taken <= tick_ch.valid && tick_ch.ready;
  end

  // Hard stop
  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

  // Offer one tick item and hold it until taken
  task automatic feed_tick(input logic tk);
    tick_ch.valid <= 1'b1;
    tick_ch.tick  <= tk;
    do @(negedge clk); while (!tick_taken);
    ticks_sent++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic settle();
    tick_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(negedge clk);
  endtask

  // Drive one register write for a cycle; caller lowers the enable
  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  // Write all registers plus one index the block ignores
  task automatic apply_setup(input setup_t s);
    settle();
    cfg_write(REG_FRAME_PERIOD, s.period);
    cfg_write(REG_SWEEP_LOW, s.low);
    cfg_write(REG_SWEEP_HIGH, s.high);
    cfg_write(REG_SWEEP_STEP, s.step);
    cfg_write(REG_FRAMES_PER_STEP, s.fps_word);
    cfg_write(REG_WIDTH_B, s.width_b);
    cfg_write(setups[0] ? RegLast : RegSpare, 16'($urandom));
    cfg_we <= 1'b0;
    setups++;
  endtask

  // Change a single register between items
  task automatic write_one(input logic [CfgIdxBits-1:0] idx, input logic [15:0] value);
    settle();
    cfg_write(idx, value);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random ready runs and one long hold-off to back up the input
  initial begin : receiver
    int unsigned r;
    int unsigned run;
    logic        rdy;
    bit          held;
    held         = 1'b0;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && ticks_sent >= HoldAfter) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          rdy = 1'b1;
          run = $urandom_range(1, 40);
        end else if (r < 88) begin
          rdy = 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          rdy = 1'b0;
          run = $urandom_range(6, 40);
        end
        res_ch.ready <= rdy;
        repeat (run) @(negedge clk);
      end
    end
  end

  // Sender: directed items, then phases of random ticks under changing setups
  initial begin : stimulus
    setup_t      s;
    int unsigned gap;
    int unsigned r;
    logic        tk;
    tick_ch.valid = 1'b0;
    tick_ch.tick  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_FRAME_PERIOD;
    cfg_data      = '0;
    rst_n         = 1'b0;
    ticks_sent    = 0;
    setups        = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Defaults: held ticks between live ones
    feed_tick(1'b0);
    feed_tick(1'b1);
    feed_tick(1'b1);
    feed_tick(1'b0);
    repeat (3) feed_tick(1'b1);
    feed_tick(1'b0);

    // Period dropped under the running count, then zero
    write_one(REG_FRAME_PERIOD, 16'd1);
    repeat (3) feed_tick(1'b1);
    write_one(REG_FRAME_PERIOD, 16'd0);
    feed_tick(1'b1);
    feed_tick(1'b0);
    feed_tick(1'b1);

    // Zero widths, zero step, zero frames per step: both channels stay high
    s = '{16'd4, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    apply_setup(s);
    repeat (6) feed_tick(1'b1);

    // Channel B width beyond the frame
    write_one(REG_WIDTH_B, 16'hFFFF);
    repeat (4) feed_tick(1'b1);

    // Phase order: period, low, high, step, frames per step, width B
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: s = '{16'd2, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1};
        1: s = '{16'd3, 16'd500, 16'd100, 16'd7, 16'd0, 16'd2};
        2: s = '{16'd5, 16'd40000, 16'hFFFF, 16'd40000, 16'h0102, 16'd3};
        3: s = '{16'hFFFF, 16'd0, 16'd10, 16'd1, 16'd1, 16'd60};
        default: begin
          s.period   = 16'($urandom_range(2, 48));
          s.low      = 16'($urandom_range(0, 40));
          s.high     = 16'($urandom_range(0, 60));
          s.step     = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 20));
          s.fps_word = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
          s.width_b  = 16'($urandom_range(0, s.period + 3));
        end
      endcase
      apply_setup(s);
      for (int n = 0; n < PhaseItems; n++) begin
        tk = ($urandom_range(0, 9) != 0);
        feed_tick(tk);
        // Odd phases run back to back
        gap = 0;
        if (p[0] == 1'b0) begin
          r = $urandom_range(0, 99);
          if (r >= 92) gap = $urandom_range(6, 30);
          else if (r >= 65) gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
          tick_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    settle();
    $display("run covered %0d tick items over %0d register setups", ticks_sent, setups);
    $display("results checked: %0d, frame starts among them: %0d", checked, frames);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
